FILE: hw/rtl/ceta_pkg.sv
// Shared types, constants and the control store for the countdown event table.
// Used by ceta_seq, ceta_dp and countdown_event_table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ceta_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int DELAY_BITS  = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [31:0] DELAY_MAX = 32'((64'd1 << DELAY_BITS) - 64'd1);

	localparam logic [0:0] REG_LOCATION_LIMIT = 1'd0;

	typedef enum logic [2:0] {
		KIND_INSERTED     = 3'd0,
		KIND_BAD_LOCATION = 3'd1,
		KIND_ZERO_DELAY   = 3'd2,
		KIND_FULL         = 3'd3,
		KIND_EXPIRED      = 3'd4,
		KIND_NONE         = 3'd5
	} kind_t;

	typedef logic [3:0] step_t;

	localparam step_t S_DISPATCH = 4'd0;
	localparam step_t S_INSERT   = 4'd1;
	localparam step_t S_TICK     = 4'd2;
	localparam step_t S_DEC      = 4'd3;
	localparam step_t S_TOP      = 4'd4;
	localparam step_t S_EMIT     = 4'd5;
	localparam step_t S_REWIND   = 4'd6;
	localparam step_t S_COMPACT  = 4'd7;
	localparam step_t S_COMMIT   = 4'd8;
	localparam step_t S_NONE     = 4'd9;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_GOTO,
		BR_DISPATCH,
		BR_IF_EMPTY,
		BR_IF_NOEXP,
		BR_UNTIL_TOP,
		BR_UNTIL_BOTTOM
	} br_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_TOP,
		IDX_UP,
		IDX_DOWN
	} idx_op_t;

	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_LOAD,
		ACT_INSERT,
		ACT_DEC,
		ACT_EMIT,
		ACT_COMPACT,
		ACT_COMMIT,
		ACT_NONE_RES
	} act_t;

	typedef struct packed {
		br_t     br;
		step_t   target;
		idx_op_t idx_op;
		act_t    act;
	} ucw_t;

	typedef struct packed {
		logic empty;
		logic at_top;
		logic at_bottom;
		logic no_exp;
	} dp_status_t;

	function automatic ucw_t ucode_rom(input step_t step);
		ucw_t w;
		unique case (step)
			S_DISPATCH: w = '{br: BR_DISPATCH,     target: S_DISPATCH, idx_op: IDX_ZERO,
				act: ACT_LOAD};
			S_INSERT:   w = '{br: BR_GOTO,         target: S_DISPATCH, idx_op: IDX_HOLD,
				act: ACT_INSERT};
			S_TICK:     w = '{br: BR_IF_EMPTY,     target: S_NONE,     idx_op: IDX_ZERO,
				act: ACT_IDLE};
			S_DEC:      w = '{br: BR_UNTIL_TOP,    target: S_DISPATCH, idx_op: IDX_UP,
				act: ACT_DEC};
			S_TOP:      w = '{br: BR_IF_NOEXP,     target: S_NONE,     idx_op: IDX_TOP,
				act: ACT_IDLE};
			S_EMIT:     w = '{br: BR_UNTIL_BOTTOM, target: S_DISPATCH, idx_op: IDX_DOWN,
				act: ACT_EMIT};
			S_REWIND:   w = '{br: BR_NEXT,         target: S_DISPATCH, idx_op: IDX_ZERO,
				act: ACT_IDLE};
			S_COMPACT:  w = '{br: BR_UNTIL_TOP,    target: S_DISPATCH, idx_op: IDX_UP,
				act: ACT_COMPACT};
			S_COMMIT:   w = '{br: BR_GOTO,         target: S_DISPATCH, idx_op: IDX_HOLD,
				act: ACT_COMMIT};
			S_NONE:     w = '{br: BR_GOTO,         target: S_DISPATCH, idx_op: IDX_HOLD,
				act: ACT_NONE_RES};
			default:    w = '{br: BR_GOTO,         target: S_DISPATCH, idx_op: IDX_HOLD,
				act: ACT_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/countdown_event_table.sv
// Flow: an insert is checked and its result word registered in the insert step; a tick
// on an empty table goes to the none word; a tick over entries runs a decrement scan first,
// then gives the none word if nothing expired, else emits expiries newest first and compacts.
// One item at a time: busy stays high until the sequencer is back at dispatch.
// Reset: arst_n clears the table (empty) and sets location_limit to 65535.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module countdown_event_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [15:0] location,
	input  wire logic [15:0] delay,
	input  wire logic [7:0]  command_handle,
	output logic             result_valid,
	output logic [2:0]       kind,
	output logic [15:0]      out_location,
	output logic [7:0]       out_handle,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]          limit_q;
	ceta_pkg::ucw_t       ctrl;
	ceta_pkg::dp_status_t status;

	assign pready = 1'b1;
	assign prdata = {16'd0, limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'hFFFF;
		end else if (psel && penable && pwrite && pready &&
			paddr[2:2] == ceta_pkg::REG_LOCATION_LIMIT) begin
			limit_q <= pwdata[15:0];
		end
	end

	ceta_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	ceta_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.start          (start),
		.location       (location),
		.delay          (delay),
		.command_handle (command_handle),
		.location_limit (limit_q),
		.status         (status),
		.result_valid   (result_valid),
		.kind           (kind),
		.out_location   (out_location),
		.out_handle     (out_handle),
		.last           (last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/ceta_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on ceta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ceta_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  cmd,
	input  wire ceta_pkg::dp_status_t  status,
	output ceta_pkg::ucw_t             ctrl,
	output logic                       busy
);

	ceta_pkg::step_t step_q;
	ceta_pkg::step_t step_d;
	ceta_pkg::step_t step_inc;

	assign ctrl     = ceta_pkg::ucode_rom(step_q);
	assign step_inc = step_q + 4'd1;
	assign busy     = (step_q != ceta_pkg::S_DISPATCH);

	always_comb begin
		unique case (ctrl.br)
			ceta_pkg::BR_NEXT:         step_d = step_inc;
			ceta_pkg::BR_GOTO:         step_d = ctrl.target;
			ceta_pkg::BR_DISPATCH: begin
				if (!start) step_d = step_q;
				else if (cmd) step_d = ceta_pkg::S_INSERT;
				else step_d = ceta_pkg::S_TICK;
			end
			ceta_pkg::BR_IF_EMPTY:     step_d = status.empty ? ctrl.target : step_inc;
			ceta_pkg::BR_IF_NOEXP:     step_d = status.no_exp ? ctrl.target : step_inc;
			ceta_pkg::BR_UNTIL_TOP:    step_d = status.at_top ? step_inc : step_q;
			ceta_pkg::BR_UNTIL_BOTTOM: step_d = status.at_bottom ? step_inc : step_q;
			default:                   step_d = ceta_pkg::S_DISPATCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ceta_pkg::S_DISPATCH;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ceta_dp.sv
// Datapath: entry table, scan index, expiry and keep counters, result register.
// Driven by control words from ceta_seq. Depends on ceta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ceta_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ceta_pkg::ucw_t              ctrl,
	input  wire logic                        start,
	input  wire logic [15:0]                 location,
	input  wire logic [15:0]                 delay,
	input  wire logic [7:0]                  command_handle,
	input  wire logic [15:0]                 location_limit,
	output ceta_pkg::dp_status_t             status,
	output logic                             result_valid,
	output logic [2:0]                       kind,
	output logic [15:0]                      out_location,
	output logic [7:0]                       out_handle,
	output logic                             last
);

	localparam int IW = ceta_pkg::IDX_W;
	localparam int CW = ceta_pkg::CNT_W;
	localparam int DW = ceta_pkg::DELAY_BITS;

	logic [DW-1:0] rem_q [ceta_pkg::TABLE_DEPTH];
	logic [15:0]   loc_q [ceta_pkg::TABLE_DEPTH];
	logic [7:0]    hdl_q [ceta_pkg::TABLE_DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] keep_q;
	logic [CW-1:0] nexp_q;
	logic [IW-1:0] idx_q;

	logic [15:0]   in_loc_q;
	logic [15:0]   in_dly_q;
	logic [7:0]    in_hdl_q;

	logic          res_valid_q;
	ceta_pkg::kind_t res_kind_q;
	logic [15:0]   res_loc_q;
	logic [7:0]    res_hdl_q;
	logic          res_last_q;

	logic [DW-1:0] rd_rem;
	logic [DW-1:0] dec_rem;
	logic [CW-1:0] count_m1;
	logic [31:0]   dly_wide;
	logic [31:0]   dly_sat;
	ceta_pkg::kind_t ins_kind;

	assign rd_rem   = rem_q[idx_q];
	assign dec_rem  = rd_rem - DW'(1);
	assign count_m1 = count_q - CW'(1);
	assign dly_wide = 32'(in_dly_q);
	assign dly_sat  = (dly_wide > ceta_pkg::DELAY_MAX) ? ceta_pkg::DELAY_MAX : dly_wide;

	always_comb begin
		if (in_loc_q >= location_limit) ins_kind = ceta_pkg::KIND_BAD_LOCATION;
		else if (in_dly_q == 16'd0) ins_kind = ceta_pkg::KIND_ZERO_DELAY;
		else if (count_q == CW'(ceta_pkg::TABLE_DEPTH)) ins_kind = ceta_pkg::KIND_FULL;
		else ins_kind = ceta_pkg::KIND_INSERTED;
	end

	assign status.empty     = (count_q == '0);
	assign status.at_top    = (CW'(idx_q) == count_m1);
	assign status.at_bottom = (idx_q == '0);
	assign status.no_exp    = (nexp_q == '0);

	// control registers and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			keep_q      <= '0;
			nexp_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;

			unique case (ctrl.idx_op)
				ceta_pkg::IDX_HOLD: idx_q <= idx_q;
				ceta_pkg::IDX_ZERO: idx_q <= '0;
				ceta_pkg::IDX_TOP:  idx_q <= count_m1[IW-1:0];
				ceta_pkg::IDX_UP:   idx_q <= idx_q + IW'(1);
				ceta_pkg::IDX_DOWN: idx_q <= idx_q - IW'(1);
				default:            idx_q <= idx_q;
			endcase

			unique case (ctrl.act)
				ceta_pkg::ACT_LOAD: begin
					if (start) begin
						keep_q <= '0;
						nexp_q <= '0;
					end
				end
				ceta_pkg::ACT_INSERT: begin
					res_valid_q <= 1'b1;
					if (ins_kind == ceta_pkg::KIND_INSERTED) count_q <= count_q + CW'(1);
				end
				ceta_pkg::ACT_DEC: begin
					if (dec_rem == '0) nexp_q <= nexp_q + CW'(1);
				end
				ceta_pkg::ACT_EMIT: begin
					if (rd_rem == '0) begin
						res_valid_q <= 1'b1;
						nexp_q      <= nexp_q - CW'(1);
					end
				end
				ceta_pkg::ACT_COMPACT: begin
					if (rd_rem != '0) keep_q <= keep_q + CW'(1);
				end
				ceta_pkg::ACT_COMMIT:   count_q <= keep_q;
				ceta_pkg::ACT_NONE_RES: res_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload: item capture, table writes, result word
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ceta_pkg::ACT_LOAD: begin
				if (start) begin
					in_loc_q <= location;
					in_dly_q <= delay;
					in_hdl_q <= command_handle;
				end
			end
			ceta_pkg::ACT_INSERT: begin
				if (ins_kind == ceta_pkg::KIND_INSERTED) begin
					rem_q[count_q[IW-1:0]] <= dly_sat[DW-1:0];
					loc_q[count_q[IW-1:0]] <= in_loc_q;
					hdl_q[count_q[IW-1:0]] <= in_hdl_q;
				end
				res_kind_q <= ins_kind;
				res_loc_q  <= '0;
				res_hdl_q  <= '0;
				res_last_q <= 1'b1;
			end
			ceta_pkg::ACT_DEC: rem_q[idx_q] <= dec_rem;
			ceta_pkg::ACT_EMIT: begin
				res_kind_q <= ceta_pkg::KIND_EXPIRED;
				res_loc_q  <= loc_q[idx_q];
				res_hdl_q  <= hdl_q[idx_q];
				res_last_q <= (nexp_q == CW'(1));
			end
			ceta_pkg::ACT_COMPACT: begin
				if (rd_rem != '0) begin
					rem_q[keep_q[IW-1:0]] <= rd_rem;
					loc_q[keep_q[IW-1:0]] <= loc_q[idx_q];
					hdl_q[keep_q[IW-1:0]] <= hdl_q[idx_q];
				end
			end
			ceta_pkg::ACT_NONE_RES: begin
				res_kind_q <= ceta_pkg::KIND_NONE;
				res_loc_q  <= '0;
				res_hdl_q  <= '0;
				res_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign out_location = res_loc_q;
	assign out_handle   = res_hdl_q;
	assign last         = res_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ceta_pkg::TABLE_DEPTH))
		else $error("entry count above table depth");

	a_nexp_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == ceta_pkg::ACT_EMIT && rd_rem == '0) |-> nexp_q != '0)
		else $error("more expiries emitted than counted");

	a_keep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.act == ceta_pkg::ACT_COMMIT |-> keep_q < count_q)
		else $error("compaction kept more entries than it scanned");

	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q) |=> !res_valid_q)
		else $error("result word directly after a last word");
`endif

endmodule

`default_nettype wire

FILE: verif/countdown_event_table_checker.sv
// Checker for countdown_event_table: watches the item, result and APB channels,
// keeps its own copy of the event table, and compares every result word.
// Depends on ceta_pkg for kind codes, table depth, delay width and register index.
`timescale 1ns / 1ps

module countdown_event_table_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        cmd,
	input  wire logic [15:0] location,
	input  wire logic [15:0] delay,
	input  wire logic [7:0]  command_handle,
	input  wire logic        result_valid,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] out_location,
	input  wire logic [7:0]  out_handle,
	input  wire logic        last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending,
	output int               words_checked
);

	typedef struct packed {
		ceta_pkg::kind_t kind;
		logic [15:0]     loc;
		logic [7:0]      hdl;
		logic            last;
	} result_word_t;

	result_word_t                      predicted_words[$];
	result_word_t                      due_word;
	logic [ceta_pkg::DELAY_BITS-1:0]   ticks_left[ceta_pkg::TABLE_DEPTH];
	logic [15:0]                       slot_location[ceta_pkg::TABLE_DEPTH];
	logic [7:0]                        slot_handle[ceta_pkg::TABLE_DEPTH];
	int                                slots_used;
	logic [15:0]                       limit_reg;
	int                                fail_count;
	int                                match_count;

	function automatic result_word_t make_word(ceta_pkg::kind_t k, logic [15:0] loc,
			logic [7:0] hdl, logic lst);
		result_word_t w;
		w.kind = k;
		w.loc  = loc;
		w.hdl  = hdl;
		w.last = lst;
		return w;
	endfunction

	task automatic step_table(input logic c, input logic [15:0] loc, input logic [15:0] dly,
			input logic [7:0] hdl);
		logic [31:0]     sat;
		int              expiries;
		int              emitted;
		int              keep;
		ceta_pkg::kind_t verdict;
		if (c) begin
			if (loc >= limit_reg)
				verdict = ceta_pkg::KIND_BAD_LOCATION;
			else if (dly == 16'd0)
				verdict = ceta_pkg::KIND_ZERO_DELAY;
			else if (slots_used >= ceta_pkg::TABLE_DEPTH)
				verdict = ceta_pkg::KIND_FULL;
			else begin
				sat = 32'(dly);
				if (sat > ceta_pkg::DELAY_MAX)
					sat = ceta_pkg::DELAY_MAX;
				ticks_left[slots_used]    = sat[ceta_pkg::DELAY_BITS-1:0];
				slot_location[slots_used] = loc;
				slot_handle[slots_used]   = hdl;
				slots_used++;
				verdict = ceta_pkg::KIND_INSERTED;
			end
			predicted_words.push_back(make_word(verdict, 16'd0, 8'd0, 1'b1));
		end else begin
			expiries = 0;
			for (int i = 0; i < slots_used; i++) begin
				ticks_left[i] = ticks_left[i] - 1'b1;
				if (ticks_left[i] == '0)
					expiries++;
			end
			emitted = 0;
			for (int i = slots_used - 1; i >= 0; i--) begin
				if (ticks_left[i] == '0) begin
					emitted++;
					predicted_words.push_back(make_word(ceta_pkg::KIND_EXPIRED,
						slot_location[i], slot_handle[i], emitted == expiries));
				end
			end
			keep = 0;
			for (int i = 0; i < slots_used; i++) begin
				if (ticks_left[i] != '0) begin
					ticks_left[keep]    = ticks_left[i];
					slot_location[keep] = slot_location[i];
					slot_handle[keep]   = slot_handle[i];
					keep++;
				end
			end
			slots_used = keep;
			if (expiries == 0)
				predicted_words.push_back(make_word(ceta_pkg::KIND_NONE, 16'd0, 8'd0,
					1'b1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_words.delete();
			slots_used    = 0;
			limit_reg     = 16'hFFFF;
			fail_count    = 0;
			match_count   = 0;
			errors        <= 0;
			pending       <= 0;
			words_checked <= 0;
		end else begin
			if (result_valid) begin
				if (predicted_words.size() == 0) begin
					$error("unexpected result word: kind %0d location %0d handle %0d",
						kind, out_location, out_handle);
					fail_count++;
				end else begin
					due_word = predicted_words.pop_front();
					match_count++;
					if (kind !== due_word.kind) begin
						$error("kind: expected %0d, got %0d", due_word.kind, kind);
						fail_count++;
					end
					if (out_location !== due_word.loc) begin
						$error("out_location: expected %0d, got %0d", due_word.loc,
							out_location);
						fail_count++;
					end
					if (out_handle !== due_word.hdl) begin
						$error("out_handle: expected %0d, got %0d", due_word.hdl, out_handle);
						fail_count++;
					end
					if (last !== due_word.last) begin
						$error("last: expected %0d, got %0d", due_word.last, last);
						fail_count++;
					end
				end
			end
			if (psel && penable && pready && paddr[2] == ceta_pkg::REG_LOCATION_LIMIT
					&& paddr[1:0] == 2'd0) begin
				if (pwrite)
					limit_reg = pwdata[15:0];
				else if (prdata[15:0] !== limit_reg) begin
					$error("prdata: expected %0d, got %0d", limit_reg, prdata[15:0]);
					fail_count++;
				end
			end
			if (start && !busy)
				step_table(cmd, location, delay, command_handle);
			errors        <= fail_count;
			pending       <= predicted_words.size();
			words_checked <= match_count;
		end
	end

endmodule

FILE: verif/countdown_event_table_test.sv
// Testbench top for countdown_event_table: clock, reset, item and APB stimulus
// under several location limits and idle rates. Uses ceta_pkg and the checker.
// The checker does all prediction; this module only drives and reports.
`timescale 1ns / 1ps

module countdown_event_table_test;

	localparam logic [2:0] LIMIT_ADDR = {ceta_pkg::REG_LOCATION_LIMIT, 2'b00};
	localparam int         PHASES     = 6;
	localparam int         PHASE_ITEMS = 64;
	localparam int         MAX_GAP    = 40;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic        cmd            = 1'b0;
	logic [15:0] location       = 16'd0;
	logic [15:0] delay          = 16'd0;
	logic [7:0]  command_handle = 8'd0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = 3'd0;
	logic [31:0] pwdata         = 32'd0;

	logic        busy;
	logic        result_valid;
	logic [2:0]  kind;
	logic [15:0] out_location;
	logic [7:0]  out_handle;
	logic        last;
	logic [31:0] prdata;
	logic        pready;

	int          errors;
	int          pending;
	int          words_checked;
	int          insert_count = 0;
	int          tick_count   = 0;

	always #2 clk = ~clk;

	countdown_event_table uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.location(location), .delay(delay), .command_handle(command_handle),
		.result_valid(result_valid), .kind(kind), .out_location(out_location),
		.out_handle(out_handle), .last(last), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	countdown_event_table_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.location(location), .delay(delay), .command_handle(command_handle),
		.result_valid(result_valid), .kind(kind), .out_location(out_location),
		.out_handle(out_handle), .last(last), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .pending(pending), .words_checked(words_checked)
	);

	// start stays high across back-to-back items; it is only lowered before a gap
	task automatic send_item(input logic c, input logic [15:0] loc, input logic [15:0] dly,
			input logic [7:0] hdl, input int idle_pct);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99, 0) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		cmd            <= c;
		location       <= loc;
		delay          <= dly;
		command_handle <= hdl;
		do @(posedge clk); while (busy);
		if (c)
			insert_count++;
		else
			tick_count++;
	endtask

	task automatic random_item(input logic [15:0] lim, input int idle_pct);
		logic        c;
		logic [15:0] loc;
		logic [15:0] dly;
		logic [7:0]  hdl;
		int          r;
		c   = ($urandom_range(99, 0) >= 35);
		hdl = 8'($urandom);
		r   = $urandom_range(99, 0);
		if (lim == 16'd0)
			loc = 16'($urandom);
		else if (r < 10)
			loc = 16'($urandom_range(65535, lim));
		else
			loc = 16'($urandom_range(lim - 1, 0));
		r = $urandom_range(99, 0);
		if (r < 5)
			dly = 16'd0;
		else if (r == 5)
			dly = 16'($urandom);
		else
			dly = 16'($urandom_range(12, 1));
		if (!c) begin
			loc = 16'($urandom);
			dly = 16'($urandom);
		end
		send_item(c, loc, dly, hdl, idle_pct);
	endtask

	// wait out every expected word and the compaction pass that follows it
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] limits[PHASES];
		int          idle_rates[PHASES];
		limits     = '{16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFE, 16'd300};
		limits[3]  = 16'($urandom_range(65533, 2));
		idle_rates = '{0, 70, 16, 70, 0, 16};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, check order, fill to full, multi-expiry ticks
		send_item(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
		send_item(1'b1, 16'hFFFF, 16'd0, 8'h00, 0);
		send_item(1'b1, 16'd0, 16'd0, 8'hFF, 0);
		send_item(1'b1, 16'hFFFE, 16'hFFFF, 8'hFF, 0);
		send_item(1'b1, 16'd0, 16'd1, 8'h00, 0);
		for (int i = 0; i < 14; i++)
			send_item(1'b1, 16'(i * 4099), 16'(1 + i % 3), 8'(i + 16), 0);
		send_item(1'b1, 16'd1, 16'd0, 8'h5A, 0);
		send_item(1'b1, 16'd2, 16'd5, 8'hA5, 0);
		send_item(1'b1, 16'hFFFF, 16'd5, 8'h3C, 0);
		for (int i = 0; i < 4; i++)
			send_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			apb_access(1'b1, LIMIT_ADDR, {16'($urandom), limits[p]});
			apb_access(1'b0, LIMIT_ADDR, 32'd0);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item(limits[p], idle_rates[p]);
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d inserts and %0d ticks over %0d location limits and three idle rates",
			insert_count, tick_count, PHASES);
		$display("Checked %0d result words", words_checked);
		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
